FILE: src/lie_pkg.sv
// ----------------------------------------------------------------------------
// lie_pkg
// Shared types and codes for the Lagrange interpolation evaluator.
// ----------------------------------------------------------------------------
package lie_pkg;

    localparam int MAG_W = 62;
    localparam logic [MAG_W-1:0] MAG_LIM = {MAG_W{1'b1}};

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_DUP  = 3'd1;
    localparam logic [2:0] ST_NONE = 3'd2;
    localparam logic [2:0] ST_SAT  = 3'd3;
    localparam logic [2:0] ST_DROP = 3'd4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DUP  = 4'd1;
    localparam logic [3:0] S_CAP  = 4'd2;
    localparam logic [3:0] S_J    = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_TERM = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [MAG_W-1:0] mag;
    } t_unit_out;

endpackage

FILE: src/lie_cell.sv
// ----------------------------------------------------------------------------
// lie_cell
// One node of the sample chain: holds (x, y), loads on its index, rotates.
// ----------------------------------------------------------------------------
module lie_cell #(
    parameter int K  = 0,
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  logic          i_wr,
    input  logic [IW-1:0] i_wr_idx,
    input  logic [31:0]   i_x,
    input  logic [31:0]   i_y,
    input  logic          i_rot,
    input  logic [31:0]   i_nx,
    input  logic [31:0]   i_ny,
    output logic [31:0]   o_x,
    output logic [31:0]   o_y
);
    logic [31:0] r_x;
    logic [31:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_wr && (i_wr_idx == IW'(K))) begin
            r_x <= i_x;
            r_y <= i_y;
        end else if (i_rot) begin
            r_x <= i_nx;
            r_y <= i_ny;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule

FILE: src/lie_div.sv
// ----------------------------------------------------------------------------
// lie_div
// Rounded fixed-point quotient (n << F + d/2) / d, one bit per cycle.
// ----------------------------------------------------------------------------
module lie_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_num,
    input  logic [31:0]         i_den,
    output lie_pkg::t_unit_out  o_res
);
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [31:0] r_d;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic        r_done;
    logic [32:0] rem_s;
    logic        ge;
    logic [32:0] rem_n;

    always_comb begin
        rem_s = {r_rem, r_quo[63]};
        ge    = rem_s >= {1'b0, r_d};
        rem_n = ge ? (rem_s - {1'b0, r_d}) : rem_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_d    <= i_den;
                r_rem  <= '0;
                r_quo  <= ({32'd0, i_num} << FRAC_BITS) + {33'd0, i_den[31:1]};
            end else if (r_busy) begin
                r_rem <= rem_n[31:0];
                r_quo <= {r_quo[62:0], ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_res.done = r_done;
        o_res.sat  = |r_quo[63:62];
        o_res.mag  = o_res.sat ? lie_pkg::MAG_LIM : r_quo[61:0];
    end
endmodule

FILE: src/lie_mul.sv
// ----------------------------------------------------------------------------
// lie_mul
// Rounded fixed-point magnitude product (a * b) >> F from four 32x32 parts.
// ----------------------------------------------------------------------------
module lie_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lie_pkg::MAG_W-1:0]      i_a,
    input  logic [lie_pkg::MAG_W-1:0]      i_b,
    output lie_pkg::t_unit_out             o_res
);
    logic                      r_busy;
    logic [2:0]                r_k;
    logic [lie_pkg::MAG_W-1:0] r_a;
    logic [lie_pkg::MAG_W-1:0] r_b;
    logic [63:0]               r_pp;
    logic [127:0]              r_acc;
    logic                      r_done;
    logic                      r_sat;
    logic [lie_pkg::MAG_W-1:0] r_mag;
    logic [31:0]               op_a;
    logic [31:0]               op_b;
    logic [127:0]              pp_sh;
    logic [127:0]              rnd;
    logic [127:0]              sh;

    always_comb begin
        case (r_k)
            3'd0: begin op_a = r_a[31:0];          op_b = r_b[31:0]; end
            3'd1: begin op_a = r_a[31:0];          op_b = {2'b0, r_b[61:32]}; end
            3'd2: begin op_a = {2'b0, r_a[61:32]}; op_b = r_b[31:0]; end
            3'd3: begin op_a = {2'b0, r_a[61:32]}; op_b = {2'b0, r_b[61:32]}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
        case (r_k)
            3'd1:    pp_sh = {64'd0, r_pp};
            3'd2:    pp_sh = {32'd0, r_pp, 32'd0};
            3'd3:    pp_sh = {32'd0, r_pp, 32'd0};
            3'd4:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = '0;
        endcase
        rnd = r_acc + (128'd1 << (FRAC_BITS - 1));
        sh  = rnd >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_pp  <= op_a * op_b;
                r_acc <= r_acc + pp_sh;
                r_k   <= r_k + 3'd1;
                if (r_k == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sat  <= |sh[127:62];
                    r_mag  <= (|sh[127:62]) ? lie_pkg::MAG_LIM : sh[61:0];
                end
            end
        end
    end

    always_comb begin
        o_res.done = r_done;
        o_res.sat  = r_sat;
        o_res.mag  = r_mag;
    end
endmodule

FILE: src/lagrange_interpolation_eval.sv
// ----------------------------------------------------------------------------
// lagrange_interpolation_eval
// Lagrange polynomial evaluator over a rotating chain of sample cells.
// ----------------------------------------------------------------------------
// Load: each accepted point is written into its cell, or dropped once full. Evaluate
// with n points: one duplicate pass over the chain per node, then per term a
// capture pass and n-1 factors (64-step divider, then multiplier).
// One item at a time; the next word waits until the result word is taken.
// Synchronous active-low reset clears count, dropped flag and control.
// ----------------------------------------------------------------------------
module lagrange_interpolation_eval #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,  // point_x, point_y, query_x
    input  logic [1:0]  i_s_tuser,  // action, first_point
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // interp_value
    output logic [2:0]  o_m_tuser   // status
);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int MW = lie_pkg::MAG_W;
    localparam logic [63:0] LIM64 = {2'b00, lie_pkg::MAG_LIM};

    logic [3:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [IW-1:0] r_h;
    logic [IW-1:0] r_i;
    logic          r_dup;
    logic [31:0]   r_q;
    logic [31:0]   r_xi;
    logic [31:0]   r_yi;
    logic [MW-1:0] r_li;
    logic          r_lneg;
    logic          r_fneg;
    logic          r_pneg;
    logic          r_sat;
    logic [63:0]   r_acc;
    logic          r_dstart;
    logic [31:0]   r_dn;
    logic [31:0]   r_dd;
    logic          r_mstart;
    logic [MW-1:0] r_mb;
    logic          r_ovalid;
    logic [31:0]   r_oval;
    logic [2:0]    r_ostat;

    logic [31:0] w_x [MAX_POINTS];
    logic [31:0] w_y [MAX_POINTS];
    lie_pkg::t_unit_out w_div;
    lie_pkg::t_unit_out w_mul;

    logic          acc_in;
    logic          is_load;
    logic          first;
    logic [CW-1:0] eff_cnt;
    logic          wr;
    logic [IW-1:0] wr_idx;
    logic          rot;
    logic          h_last;
    logic [IW-1:0] h_nxt;
    logic          h_in;
    logic [32:0]   dnum;
    logic [32:0]   dden;
    logic [32:0]   dnum_m;
    logic [32:0]   dden_m;
    logic [63:0]   term;
    logic [63:0]   sum;
    logic          y_neg;
    logic [31:0]   y_mag;
    logic          out_free;

    assign o_s_tready = (r_state == lie_pkg::S_IDLE) && !r_ovalid;
    assign acc_in     = i_s_tvalid && o_s_tready;
    assign is_load    = (i_s_tuser[0] == lie_pkg::ACT_LOAD);
    assign first      = i_s_tuser[1];
    assign eff_cnt    = first ? '0 : r_cnt;
    assign wr         = acc_in && is_load && (eff_cnt < CW'(MAX_POINTS));
    assign wr_idx     = eff_cnt[IW-1:0];
    assign h_last     = (r_h == IW'(MAX_POINTS - 1));
    assign h_nxt      = h_last ? '0 : r_h + IW'(1);
    assign h_in       = ({{(CW-IW){1'b0}}, r_h} < r_cnt);
    assign out_free   = !r_ovalid || i_m_tready;

    assign rot = (r_state == lie_pkg::S_DUP) || (r_state == lie_pkg::S_CAP)
              || ((r_state == lie_pkg::S_J) && !(h_in && r_h != r_i))
              || ((r_state == lie_pkg::S_MUL) && w_mul.done);

    genvar k;
    generate
        for (k = 0; k < MAX_POINTS; k++) begin : g_cell
            localparam int NXT = (k + 1) % MAX_POINTS;
            lie_cell #(.K(k), .IW(IW)) u_cell (
                .i_clk    (i_clk),
                .i_wr     (wr),
                .i_wr_idx (wr_idx),
                .i_x      (i_s_tdata[31:0]),
                .i_y      (i_s_tdata[63:32]),
                .i_rot    (rot),
                .i_nx     (w_x[NXT]),
                .i_ny     (w_y[NXT]),
                .o_x      (w_x[k]),
                .o_y      (w_y[k])
            );
        end
    endgenerate

    lie_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dn),
        .i_den   (r_dd),
        .o_res   (w_div)
    );

    lie_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_li),
        .i_b     (r_mb),
        .o_res   (w_mul)
    );

    always_comb begin
        dnum   = {r_q[31], r_q} - {w_x[0][31], w_x[0]};
        dden   = {r_xi[31], r_xi} - {w_x[0][31], w_x[0]};
        dnum_m = dnum[32] ? -dnum : dnum;
        dden_m = dden[32] ? -dden : dden;
        y_neg  = r_yi[31];
        y_mag  = y_neg ? -r_yi : r_yi;
        term   = r_pneg ? -{2'b00, w_mul.mag} : {2'b00, w_mul.mag};
        sum    = r_acc + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lie_pkg::S_IDLE;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_h      <= '0;
            r_i      <= '0;
            r_dstart <= 1'b0;
            r_mstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            r_mstart <= 1'b0;
            if (r_ovalid && i_m_tready) r_ovalid <= 1'b0;
            if (rot) r_h <= h_nxt;
            case (r_state)
                lie_pkg::S_IDLE: begin
                    if (acc_in && is_load) begin
                        if (first) r_drop <= 1'b0;
                        if (eff_cnt < CW'(MAX_POINTS)) begin
                            r_cnt <= eff_cnt + CW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end else if (acc_in) begin
                        r_q   <= i_s_tdata[95:64];
                        r_i   <= '0;
                        r_dup <= 1'b0;
                        if (r_cnt == '0) begin
                            r_oval  <= '0;
                            r_ostat <= lie_pkg::ST_NONE;
                            r_state <= lie_pkg::S_OUT;
                        end else begin
                            r_state <= lie_pkg::S_DUP;
                        end
                    end
                end
                lie_pkg::S_DUP: begin
                    if (r_h == r_i) r_xi <= w_x[0];
                    if ((r_h > r_i) && h_in && (w_x[0] == r_xi)) r_dup <= 1'b1;
                    if (h_last) begin
                        if (r_dup || ((r_h > r_i) && h_in && (w_x[0] == r_xi))) begin
                            r_oval  <= '0;
                            r_ostat <= lie_pkg::ST_DUP;
                            r_state <= lie_pkg::S_OUT;
                        end else if ({{(CW-IW){1'b0}}, r_i} == r_cnt - CW'(1)) begin
                            r_i     <= '0;
                            r_acc   <= '0;
                            r_sat   <= 1'b0;
                            r_state <= lie_pkg::S_CAP;
                        end else begin
                            r_i <= r_i + IW'(1);
                        end
                    end
                end
                lie_pkg::S_CAP: begin
                    if (r_h == r_i) begin
                        r_xi <= w_x[0];
                        r_yi <= w_y[0];
                    end
                    if (h_last) begin
                        r_li    <= MW'(1) << FRAC_BITS;
                        r_lneg  <= 1'b0;
                        r_state <= lie_pkg::S_J;
                    end
                end
                lie_pkg::S_J: begin
                    if (h_in && r_h != r_i) begin
                        r_dn     <= dnum_m[31:0];
                        r_dd     <= dden_m[31:0];
                        r_fneg   <= dnum[32] ^ dden[32];
                        r_dstart <= 1'b1;
                        r_state  <= lie_pkg::S_DIV;
                    end else if (h_last) begin
                        r_mb     <= {{(MW-32){1'b0}}, y_mag};
                        r_pneg   <= r_lneg ^ y_neg;
                        r_mstart <= 1'b1;
                        r_state  <= lie_pkg::S_TERM;
                    end
                end
                lie_pkg::S_DIV: begin
                    if (w_div.done) begin
                        r_sat    <= r_sat | w_div.sat;
                        r_mb     <= w_div.mag;
                        r_pneg   <= r_lneg ^ (r_fneg && (w_div.mag != '0));
                        r_mstart <= 1'b1;
                        r_state  <= lie_pkg::S_MUL;
                    end
                end
                lie_pkg::S_MUL: begin
                    if (w_mul.done) begin
                        r_li   <= w_mul.mag;
                        r_lneg <= r_pneg && (w_mul.mag != '0);
                        r_sat  <= r_sat | w_mul.sat;
                        if (h_last) begin
                            r_mb     <= {{(MW-32){1'b0}}, y_mag};
                            r_pneg   <= (r_pneg && (w_mul.mag != '0)) ^ y_neg;
                            r_mstart <= 1'b1;
                            r_state  <= lie_pkg::S_TERM;
                        end else begin
                            r_state <= lie_pkg::S_J;
                        end
                    end
                end
                lie_pkg::S_TERM: begin
                    if (w_mul.done) begin
                        if ($signed(sum) > $signed(LIM64)) begin
                            r_acc <= LIM64;
                            r_sat <= 1'b1;
                        end else if ($signed(sum) < -$signed(LIM64)) begin
                            r_acc <= -LIM64;
                            r_sat <= 1'b1;
                        end else begin
                            r_acc <= sum;
                            r_sat <= r_sat | w_mul.sat;
                        end
                        if ({{(CW-IW){1'b0}}, r_i} == r_cnt - CW'(1)) begin
                            r_state <= lie_pkg::S_FIN;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= lie_pkg::S_CAP;
                        end
                    end
                end
                lie_pkg::S_FIN: begin
                    if ($signed(r_acc) > 64'sh7FFF_FFFF) begin
                        r_oval  <= 32'h7FFF_FFFF;
                        r_ostat <= lie_pkg::ST_SAT;
                    end else if ($signed(r_acc) < -64'sh8000_0000) begin
                        r_oval  <= 32'h8000_0000;
                        r_ostat <= lie_pkg::ST_SAT;
                    end else begin
                        r_oval  <= r_acc[31:0];
                        r_ostat <= r_sat ? lie_pkg::ST_SAT
                                 : (r_drop ? lie_pkg::ST_DROP : lie_pkg::ST_OK);
                    end
                    r_state <= lie_pkg::S_OUT;
                end
                lie_pkg::S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= lie_pkg::S_IDLE;
                    end
                end
                default: r_state <= lie_pkg::S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oval;
    assign o_m_tuser  = r_ostat;

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_chain_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lie_pkg::S_IDLE) |-> (r_h == '0))
        else $error("chain not at home position while idle");

    a_div_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == lie_pkg::S_DIV))
        else $error("divider finished outside factor step");

    a_mul_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul.done |-> (r_state == lie_pkg::S_MUL || r_state == lie_pkg::S_TERM))
        else $error("multiplier finished outside product step");
endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lagrange_interpolation_eval. Sample points are
// loaded and evaluate words are sent over the slave stream. Each expected
// result comes from a fixed-point interpolation predictor or the directed table
// and is matched field by field against the master stream. Directed rows and
// overflow loads lead, then random sets, most with sender/receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int NPTS = 16;
    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } t_interp;

    typedef struct {
        logic        act;
        logic        first;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] qx;
        bit          typed;
        logic [31:0] val;
        logic [2:0]  st;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;  // point_x, point_y, query_x
    logic [1:0]  i_s_tuser;  // action, first_point
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;  // interp_value
    logic [2:0]  o_m_tuser;  // status

    lagrange_interpolation_eval dut (.*);

    logic [31:0] node_x [NPTS];
    logic [31:0] node_y [NPTS];
    int          node_cnt;
    bit          node_dropped;
    t_interp     pending_results [$];
    int          fail_count;
    int          tx_idle;
    int          rx_idle;
    int          stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b,
                                            inout bit sat);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        if (p > {66'b0, lie_pkg::MAG_LIM}) begin
            sat = 1'b1;
            return {2'b0, lie_pkg::MAG_LIM};
        end
        return p[63:0];
    endfunction

    function automatic longint sfix_mul(input longint a, input longint b, inout bit sat);
        logic [63:0] m;
        m = fix_mul(mag64(a), mag64(b), sat);
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sfix_div(input longint num, input longint den, inout bit sat);
        logic [63:0] n, d, q;
        n = mag64(num);
        d = mag64(den);
        q = ((n << FRAC) + (d >> 1)) / d;
        if (q > {2'b0, lie_pkg::MAG_LIM}) begin
            sat = 1'b1;
            q = {2'b0, lie_pkg::MAG_LIM};
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_interp interpolate(input logic [31:0] qraw);
        t_interp r;
        longint q, acc, li, xi, xj, lim;
        bit sat;
        lim = longint'({2'b0, lie_pkg::MAG_LIM});
        acc = 0;
        sat = 1'b0;
        if (node_cnt == 0) begin
            r.value = '0;
            r.status = lie_pkg::ST_NONE;
            return r;
        end
        for (int i = 0; i < node_cnt; i++)
            for (int j = i + 1; j < node_cnt; j++)
                if (node_x[i] == node_x[j]) begin
                    r.value = '0;
                    r.status = lie_pkg::ST_DUP;
                    return r;
                end
        q = longint'(signed'(qraw));
        for (int i = 0; i < node_cnt; i++) begin
            xi = longint'(signed'(node_x[i]));
            li = longint'(1) << FRAC;
            for (int j = 0; j < node_cnt; j++) begin
                if (j != i) begin
                    xj = longint'(signed'(node_x[j]));
                    li = sfix_mul(li, sfix_div(q - xj, xi - xj, sat), sat);
                end
            end
            acc = acc + sfix_mul(li, longint'(signed'(node_y[i])), sat);
            if (acc > lim) begin
                acc = lim;
                sat = 1'b1;
            end else if (acc < -lim) begin
                acc = -lim;
                sat = 1'b1;
            end
        end
        if (acc > 64'sh7FFF_FFFF) begin
            acc = 64'sh7FFF_FFFF;
            sat = 1'b1;
        end else if (acc < -64'sh8000_0000) begin
            acc = -64'sh8000_0000;
            sat = 1'b1;
        end
        r.value = acc[31:0];
        r.status = sat ? lie_pkg::ST_SAT
                 : (node_dropped ? lie_pkg::ST_DROP : lie_pkg::ST_OK);
        return r;
    endfunction

    task automatic send_word(input logic act, input logic first, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] qx,
                             input bit typed, input t_interp fixed_res);
        while ($urandom_range(99) < tx_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {qx, py, px};
        i_s_tuser <= {first, act};
        do @(posedge i_clk); while (!o_s_tready);
        if (act == lie_pkg::ACT_LOAD) begin
            if (first) begin
                node_cnt = 0;
                node_dropped = 1'b0;
            end
            if (node_cnt < NPTS) begin
                node_x[node_cnt] = px;
                node_y[node_cnt] = py;
                node_cnt++;
            end else begin
                node_dropped = 1'b1;
            end
        end else begin
            pending_results.push_back(typed ? fixed_res : interpolate(qx));
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0, 1: return $urandom();
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(($urandom_range(40) - 20) * ONE + $urandom_range(65535));
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int sent, k;
        logic [31:0] xs [NPTS + 4];
        logic [31:0] q;
        t_interp none;
        none = '0;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(19) == 0) begin
                // noise: stray load appended or eval on whatever is stored
                if ($urandom_range(1))
                    send_word(lie_pkg::ACT_LOAD, 1'b0, rand_coord(), rand_coord(),
                              $urandom(), 0, none);
                else
                    send_word(lie_pkg::ACT_EVAL, 1'($urandom_range(1)), $urandom(),
                              $urandom(), rand_coord(), 0, none);
                sent++;
            end else begin
                k = $urandom_range(99);
                k = k < 3 ? NPTS : (k < 6 ? NPTS + $urandom_range(1, 3) : $urandom_range(1, 6));
                for (int i = 0; i < k; i++) begin
                    xs[i] = rand_coord();
                    if (i > 0 && $urandom_range(29) == 0)
                        xs[i] = xs[$urandom_range(i - 1)];
                    send_word(lie_pkg::ACT_LOAD, i == 0, xs[i], rand_coord(), $urandom(),
                              0, none);
                end
                for (int e = $urandom_range(1, 3); e > 0; e--) begin
                    q = $urandom_range(2) == 0 ? xs[$urandom_range(k - 1)] : rand_coord();
                    send_word(lie_pkg::ACT_EVAL, 1'($urandom_range(1)), $urandom(),
                              $urandom(), q, 0, none);
                    sent++;
                end
                sent += k;
            end
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_interp exp_res;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL lagrange_interpolation_eval");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report($sformatf("unexpected word value=%h status=%0d",
                                     o_m_tdata, o_m_tuser));
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_m_tdata !== exp_res.value)
                        report($sformatf("value %h, expected %h", o_m_tdata, exp_res.value));
                    if (o_m_tuser !== exp_res.status)
                        report($sformatf("status %0d, expected %0d",
                                         o_m_tuser, exp_res.status));
                end
            end
        end
        i_m_tready <= $urandom_range(99) >= rx_idle;
    end

    initial begin
        t_row rows [$];
        t_interp fixed_res;
        int waited;
        rows = '{
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 0, 1, 0, lie_pkg::ST_NONE},
            '{lie_pkg::ACT_LOAD, 1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 32'h1234, 1, 32'h7FFF_FFFF, lie_pkg::ST_OK},
            '{lie_pkg::ACT_LOAD, 1, ONE, 2 * ONE, 0, 0, 0, 0},
            '{lie_pkg::ACT_LOAD, 0, ONE, 3 * ONE, 0, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 0, 1, 0, lie_pkg::ST_DUP},
            '{lie_pkg::ACT_EVAL, 1, 0, 0, ONE, 1, 0, lie_pkg::ST_DUP},
            '{lie_pkg::ACT_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0},
            '{lie_pkg::ACT_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 0, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 32'h8000_0000, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0},
            '{lie_pkg::ACT_LOAD, 1, 0, ONE, 0, 0, 0, 0},
            '{lie_pkg::ACT_LOAD, 0, ONE, 2 * ONE, 0, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 32'h0000_8000, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, ONE, 0, 0, 0},
            '{lie_pkg::ACT_EVAL, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0}
        };
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        fail_count = 0;
        stall_cycles = 0;
        node_cnt = 0;
        node_dropped = 1'b0;
        tx_idle = 28;
        rx_idle = 76;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            fixed_res.value = rows[r].val;
            fixed_res.status = rows[r].st;
            send_word(rows[r].act, rows[r].first, rows[r].px, rows[r].py, rows[r].qx,
                      rows[r].typed, fixed_res);
        end
        // store full, then overflow loads mark points dropped
        for (int i = 0; i < NPTS + 2; i++)
            send_word(lie_pkg::ACT_LOAD, i == 0, i * ONE, 32'(i - 8), 0, 0, fixed_res);
        send_word(lie_pkg::ACT_EVAL, 0, 0, 0, 32'h0003_8000, 0, fixed_res);
        send_word(lie_pkg::ACT_EVAL, 0, 0, 0, 5 * ONE, 0, fixed_res);

        random_phase(550);
        tx_idle = 76;
        rx_idle = 28;
        random_phase(550);
        tx_idle = 0;
        rx_idle = 0;
        random_phase(550);

        waited = 0;
        while (pending_results.size() != 0 && waited < 20 * WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0) begin
            $display("PASS lagrange_interpolation_eval");
        end else begin
            $display("FAIL lagrange_interpolation_eval");
        end
        $finish;
    end

endmodule

FILE: lagrange_interpolation_eval.f
src/lie_pkg.sv
src/lie_cell.sv
src/lie_div.sv
src/lie_mul.sv
src/lagrange_interpolation_eval.sv
sim/testbench.sv
